@@ hdl/lpfi_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register indexes and control types for the loop playhead
// frame index core. No dependencies.
package lpfi_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int FCNT_W      = 11;
    localparam int IDX_W       = 10;
    localparam int SEL_W       = 17;
    localparam int POS_W       = 32;
    localparam int STRETCH_W   = 24;
    localparam int FRAC_W      = 16;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 27;
    localparam int U_W         = 41;
    localparam int X_W         = 51;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int DIV_STEPS   = 48;
    localparam int DIV_CNT_W   = 6;

    localparam logic [FCNT_W-1:0] MAX_FRAMES_N = FCNT_W'(MAX_FRAMES);
    localparam logic [SEL_W-1:0]  SEL_ONE      = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PING_PONG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd4;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic update;
        logic mul1;
        logic mul2;
        logic load_out;
    } lpfi_cmd_t;

    typedef struct packed {
        logic need_div;
    } lpfi_status_t;

endpackage

@@ hdl/lpfi_item_if.sv @@
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with seek/advance payload.
// Depends on lpfi_pkg.
interface lpfi_item_if import lpfi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [STRETCH_W-1:0] stretch;
    logic signed [POS_W-1:0] new_position;

    modport source (output valid, output mode, output stretch, output new_position,
                    input ready);
    modport sink   (input valid, input mode, input stretch, input new_position,
                    output ready);
endinterface

@@ hdl/lpfi_result_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with frame index and mix payload.
// Depends on lpfi_pkg.
interface lpfi_result_if import lpfi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  frame_index;
    logic              next_valid;
    logic [FRAC_W-1:0] mix_fraction;
    logic              finished;
    logic              has_frames;

    modport source (output valid, output frame_index, output next_valid,
                    output mix_fraction, output finished, output has_frames,
                    input ready);
    modport sink   (input valid, input frame_index, input next_valid,
                    input mix_fraction, input finished, input has_frames,
                    output ready);
endinterface

@@ hdl/lpfi_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on lpfi_pkg.
interface lpfi_cfg_if import lpfi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/lpfi_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the playhead: accept, step division, update, two multiply
// stages, result load. Depends on lpfi_pkg.
module lpfi_ctrl import lpfi_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  lpfi_status_t status,
    output lpfi_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = '0;
                    state_next    = status.need_div ? ST_DIV : ST_UPD;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Load the output word once the previous one has left
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

@@ hdl/lpfi_datapath.sv @@
`timescale 1ns / 1ps
// Playhead datapath: config registers, bit-serial step divider, position
// update with saturation, fold and selection mapping. Depends on lpfi_pkg.
module lpfi_datapath import lpfi_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     item_mode,
    input  logic [STRETCH_W-1:0]     item_stretch,
    input  logic signed [POS_W-1:0]  item_new_position,
    input  lpfi_cmd_t                cmd,
    output lpfi_status_t             status,
    output logic [IDX_W-1:0]         frame_index,
    output logic                     next_valid,
    output logic [FRAC_W-1:0]        mix_fraction,
    output logic                     finished,
    output logic                     has_frames
);

    // Configuration and position state
    logic              reverse_reg;
    logic              ping_pong_reg;
    logic [SEL_W-1:0]  sel_start_reg;
    logic [SEL_W-1:0]  sel_end_reg;
    logic [FCNT_W-1:0] frame_count_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // Working registers
    logic                 mode_reg;
    logic [POS_W-1:0]     seek_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [U_W-1:0]       u_reg;
    logic                 fin_reg;
    logic [X_W-1:0]       x_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 nxt_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic                 fin_out_reg;
    logic                 has_reg;

    logic [SEL_W-1:0]  cfg_sel;
    logic [FCNT_W-1:0] n_eff;
    logic [IDX_W-1:0]  n_m1;
    logic [SEL_W-1:0]  sel_width;
    logic [DEN_W-1:0]  den_calc;

    // Clamp selection writes to one
    assign cfg_sel = (cfg_data > SEL_ONE) ? SEL_ONE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg     <= 1'b0;
            ping_pong_reg   <= 1'b0;
            sel_start_reg   <= '0;
            sel_end_reg     <= SEL_ONE;
            frame_count_reg <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_REVERSE:     reverse_reg     <= cfg_data[0];
                    REG_PING_PONG:   ping_pong_reg   <= cfg_data[0];
                    REG_SEL_START:   sel_start_reg   <= cfg_sel;
                    REG_SEL_END:     sel_end_reg     <= cfg_sel;
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data[FCNT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.update)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Effective frame count and step denominator
    assign n_eff     = (frame_count_reg > MAX_FRAMES_N) ? MAX_FRAMES_N : frame_count_reg;
    assign n_m1      = IDX_W'(n_eff - 1'b1);
    assign sel_width = sel_end_reg - sel_start_reg;
    assign den_calc  = DEN_W'(sel_width) * DEN_W'(n_m1);

    assign status.need_div = !item_mode && (n_eff > FCNT_W'(1))
                             && (sel_end_reg > sel_start_reg);

    // One quotient bit per cycle, restoring
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    // Position update with saturation
    logic [POS_W-1:0] step;
    logic [POS_W:0]   pos_sum;
    assign step = (|num_reg[NUM_W-1:POS_W-1]) ? {1'b0, {(POS_W-1){1'b1}}}
                                              : {1'b0, num_reg[POS_W-2:0]};
    assign pos_sum = reverse_reg ? ({pos_reg[POS_W-1], pos_reg} - {1'b0, step})
                                 : ({pos_reg[POS_W-1], pos_reg} + {1'b0, step});

    always_comb
    begin
        if (mode_reg)
        begin
            pos_next = seek_reg;
        end
        else if (pos_sum[POS_W] != pos_sum[POS_W-1])
        begin
            pos_next = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                      : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            pos_next = pos_sum[POS_W-1:0];
        end
    end

    // Fold the position and map into the selection
    logic signed [POS_W-1:0] pos_s;
    logic                    fin_calc;
    logic [24:0]             p25;
    logic [24:0]             t_val;
    logic signed [SEL_W:0]   sel_diff;
    logic signed [43:0]      t_prod;
    logic signed [44:0]      u_sum;

    assign pos_s = $signed(pos_reg);
    assign p25   = pos_reg[24:0];

    always_comb
    begin
        if (reverse_reg)
        begin
            fin_calc = pos_reg[POS_W-1];
        end
        else if (ping_pong_reg)
        begin
            fin_calc = pos_s > 32'sh0200_0000;
        end
        else
        begin
            fin_calc = pos_s > 32'sh0100_0000;
        end
        if (!ping_pong_reg)
        begin
            t_val = {1'b0, pos_reg[23:0]};
        end
        else if (p25 > 25'h100_0000)
        begin
            t_val = 25'(26'h200_0000 - {1'b0, p25});
        end
        else
        begin
            t_val = p25;
        end
    end

    assign sel_diff = $signed({1'b0, sel_end_reg}) - $signed({1'b0, sel_start_reg});
    assign t_prod   = $signed({1'b0, t_val}) * sel_diff;
    assign u_sum    = $signed({4'b0, sel_start_reg, 24'b0}) + $signed({t_prod[43], t_prod});

    // Result fields from the scaled position
    logic [FCNT_W-1:0] i0;
    logic              has_calc;
    logic              nxt_calc;
    assign i0       = x_reg[X_W-1:40];
    assign has_calc = frame_count_reg != '0;
    assign nxt_calc = has_calc && (({1'b0, i0} + 12'd1) < {1'b0, n_eff});

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= item_mode;
            seek_reg <= item_new_position;
            num_reg  <= status.need_div ? {item_stretch, 24'b0} : '0;
            rem_reg  <= '0;
            den_reg  <= den_calc;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[DEN_W])
            begin
                rem_reg <= rem_diff[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.mul1)
        begin
            u_reg   <= u_sum[44] ? '0 : u_sum[U_W-1:0];
            fin_reg <= fin_calc;
        end
        if (cmd.mul2)
        begin
            x_reg <= X_W'(u_reg) * X_W'(n_m1);
        end
        if (cmd.load_out)
        begin
            idx_reg     <= has_calc ? i0[IDX_W-1:0] : '0;
            nxt_reg     <= nxt_calc;
            frac_reg    <= nxt_calc ? x_reg[39:24] : '0;
            fin_out_reg <= fin_reg;
            has_reg     <= has_calc;
        end
    end

    assign frame_index  = idx_reg;
    assign next_valid   = nxt_reg;
    assign mix_fraction = frac_reg;
    assign finished     = fin_out_reg;
    assign has_frames   = has_reg;

endmodule

@@ hdl/loop_playhead_frame_index_core.sv @@
`timescale 1ns / 1ps
// Loop playhead frame index core: top level joining sequencer and datapath.
// Sequence: a seek passes the update, multiply and result load states; an
// advance with a nonzero divisor first runs the 48-step bit-serial divider.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (rst_n low, asynchronous) clears position, registers to defaults, control.
// Depends on lpfi_pkg, the channel interfaces, lpfi_ctrl and lpfi_datapath.
module loop_playhead_frame_index_core import lpfi_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    lpfi_cfg_if.sink       cfg,
    lpfi_item_if.sink      item,
    lpfi_result_if.source  result
);

    lpfi_cmd_t    cmd;
    lpfi_status_t status;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    lpfi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    lpfi_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .item_mode         (item.mode),
        .item_stretch      (item.stretch),
        .item_new_position (item.new_position),
        .cmd               (cmd),
        .status            (status),
        .frame_index       (result.frame_index),
        .next_valid        (result.next_valid),
        .mix_fraction      (result.mix_fraction),
        .finished          (result.finished),
        .has_frames        (result.has_frames)
    );

endmodule
